// ===== rtl/kpsd_pkg.sv =====
package kpsd_pkg;

	localparam int ROWS    = 4;
	localparam int COLUMNS = 8;

	localparam int PHASES  = 2 * ROWS;
	localparam int PHASE_W = 3;
	localparam int ROW_W   = 2;
	localparam int COL_W   = 3;
	localparam int CODE_W  = 5;
	localparam int GROUP   = 4;

	localparam logic [7:0] DEBOUNCE_RESET = 8'd50;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_CHANGE_LO = 2'd1;
	localparam logic [1:0] OP_CHANGE_HI = 2'd2;

	// Character of code i sits in byte 31-i, since a string literal starts at the MSB.
	localparam logic [255:0] KEY_CHARS = "=396xtln/-*+apg^0174osqm.285fced";

	typedef struct packed {
		logic [ROWS-1:0]   row_drive;
		logic              key_valid;
		logic [CODE_W-1:0] key_code;
		logic [7:0]        key_char;
	} kpsd_result_t;

	function automatic logic [7:0] kpsd_key_char(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] slot;
		slot = ~code;
		return KEY_CHARS[{slot, 3'b000} +: 8];
	endfunction

endpackage

// ===== rtl/kpsd_scan.sv =====
module kpsd_scan import kpsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	input  logic         step,
	input  logic [1:0]   op,
	input  logic [7:0]   levels,
	output kpsd_result_t result
);

	logic [PHASE_W-1:0] scan_phase_q;
	logic [ROW_W-1:0]   active_row_q;
	logic               press_lock_q;
	logic [7:0]         quiet_count_q;
	logic [7:0]         debounce_ticks_q;

	logic [PHASE_W-1:0] phase_next;
	logic [PHASE_W-1:0] phase_shown;
	logic               is_change;
	logic               found;
	logic [COL_W-1:0]   col_hit;

	function automatic logic [ROWS-1:0] scan_phase_shown_drive(input logic [PHASE_W-1:0] ph);
		if (ph[0])
			return '1;
		return ~(ROWS'(1) << ph[PHASE_W-1:1]);
	endfunction

	assign phase_next = (scan_phase_q == PHASE_W'(PHASES - 1)) ? '0 : scan_phase_q + 1'b1;
	assign is_change  = (op == OP_CHANGE_LO) || (op == OP_CHANGE_HI);
	assign phase_shown = (op == OP_TICK) ? phase_next : scan_phase_q;

	// Lowest low column of the selected group.
	always_comb begin
		logic [COL_W-1:0] col;
		found   = 1'b0;
		col_hit = '0;
		for (int i = GROUP - 1; i >= 0; i--) begin
			col = (op == OP_CHANGE_HI) ? COL_W'(GROUP + i) : COL_W'(i);
			if ((32'(col) < COLUMNS) && !levels[col]) begin
				found   = 1'b1;
				col_hit = col;
			end
		end
	end

	always_comb begin
		result.row_drive = scan_phase_shown_drive(phase_shown);
		result.key_valid = is_change && !press_lock_q && found;
		result.key_code  = '0;
		result.key_char  = '0;
		if (result.key_valid) begin
			result.key_code = CODE_W'(32'(active_row_q) * COLUMNS + 32'(col_hit));
			result.key_char = kpsd_key_char(result.key_code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_phase_q     <= '0;
			active_row_q     <= '0;
			press_lock_q     <= 1'b0;
			quiet_count_q    <= '0;
			debounce_ticks_q <= DEBOUNCE_RESET;
		end else begin
			if (cfg_wr_en)
				debounce_ticks_q <= cfg_wr_data;
			if (step && (op == OP_TICK)) begin
				if (quiet_count_q != '0)
					quiet_count_q <= quiet_count_q - 1'b1;
				else
					press_lock_q <= 1'b0;
				scan_phase_q <= phase_next;
				if (!phase_next[0])
					active_row_q <= phase_next[PHASE_W-1:1];
			end else if (step && is_change) begin
				press_lock_q  <= 1'b1;
				quiet_count_q <= debounce_ticks_q;
			end
		end
	end

endmodule

// ===== rtl/keypad_scan_debounce.sv =====
// Keypad scanner and debouncer for a 4-row by 8-column matrix. Each item is a tick
// (operation 0) or a column-change event for columns 0-3 (1) or 4-7 (2), with the
// sampled active-low column pins; every item yields exactly one result with the row
// drive after the item and, for an accepted key press, its code (row*8+column) and
// character. An item passes an input register and a result register, and one item can
// be taken every cycle while no stalled result holds the output; the state update between
// the two registers sets that rate. debounce_ticks resets to 50.
module keypad_scan_debounce import kpsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [7:0]        column_levels,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROWS-1:0]   row_drive,
	output logic              key_valid,
	output logic [CODE_W-1:0] key_code,
	output logic [7:0]        key_char
);

	logic         valid_s1;
	logic [1:0]   op_s1;
	logic [7:0]   levels_s1;
	logic         valid_s2;
	kpsd_result_t result_s2;
	kpsd_result_t result;
	logic         advance;
	logic         accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	kpsd_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.op          (op_s1),
		.levels      (levels_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			levels_s1 <= column_levels;
		end
		if (advance)
			result_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign row_drive = result_s2.row_drive;
	assign key_valid = result_s2.key_valid;
	assign key_code  = result_s2.key_code;
	assign key_char  = result_s2.key_char;

endmodule

// ===== rtl/kpsd_checker.sv =====
module kpsd_checker import kpsd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ROWS-1:0]   row_drive,
	input logic              key_valid,
	input logic [CODE_W-1:0] key_code,
	input logic [7:0]        key_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(key_code) && $stable(key_char)
			&& $stable(key_valid) && $stable(row_drive))
		else $error("stalled result item changed");

	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_code == '0 && key_char == '0)
		else $error("key fields not zero without a key");

	a_row_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_drive == '1 || $onehot(~row_drive))
		else $error("more than one row driven");

	a_key_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> key_char == kpsd_key_char(key_code))
		else $error("key character does not match its code");

endmodule

bind keypad_scan_debounce kpsd_checker u_kpsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_drive (row_drive),
	.key_valid (key_valid),
	.key_code  (key_code),
	.key_char  (key_char)
);
